// ===== rtl/gnns_pkg.sv =====
// Shared types and constants for the graph node table with nearest-node search.
// Holds command and status codes, field widths and the distance-unit request struct.
// No dependencies.
`default_nettype none

package gnns_pkg;

    // Default table size
    localparam int MAX_NODES_DEF = 64;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int POS_W      = 16;
    localparam int IDX_PORT_W = 6;
    localparam int WGT_W      = 16;
    localparam int EW_W       = 15;
    localparam int DIST_W     = 33;
    localparam int STATUS_W   = 2;

    // Last drain cycle after the final node leaves the ring; by then the distance pipeline
    // has settled its best result.
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 2'd0,
        CMD_SET_EDGE  = 2'd1,
        CMD_FIND      = 2'd2,
        CMD_READ_EDGE = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BAD   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // One node handed from the head of the ring to the distance unit
    typedef struct packed {
        logic                    valid;
        logic                    first;
        logic signed [POS_W-1:0] qx;
        logic signed [POS_W-1:0] qy;
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
    } t_dist_req;

endpackage

`default_nettype wire

// ===== rtl/gnns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the adjacency store; depends on nothing.
`default_nettype none

module gnns_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry and register the read of another
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/gnns_cell.sv =====
// One node cell of the position ring: holds x and y of one node.
// Loads a new node or takes its neighbor's node; uses gnns_pkg.
`default_nettype none

module gnns_cell (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_shift,
    input  logic signed [gnns_pkg::POS_W-1:0] i_load_x,
    input  logic signed [gnns_pkg::POS_W-1:0] i_load_y,
    input  logic signed [gnns_pkg::POS_W-1:0] i_next_x,
    input  logic signed [gnns_pkg::POS_W-1:0] i_next_y,
    output logic signed [gnns_pkg::POS_W-1:0] o_x,
    output logic signed [gnns_pkg::POS_W-1:0] o_y
);
    import gnns_pkg::*;

    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;

    // Load a new node, or advance the ring by one place
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

// ===== rtl/gnns_dist.sv =====
// Pipelined squared-distance and running-minimum unit for the nearest search.
// Three stages: absolute differences, squares, sum and compare. Uses gnns_pkg.
`default_nettype none

module gnns_dist #(
    parameter int MAX_NODES = gnns_pkg::MAX_NODES_DEF,
    localparam int IW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gnns_pkg::t_dist_req               i_req,
    output logic [IW-1:0]                     o_best_idx,
    output logic [gnns_pkg::DIST_W-1:0]       o_best_dist
);
    import gnns_pkg::*;

    localparam int SQ_W = 2 * POS_W;

    logic signed [POS_W:0]   w_dx;
    logic signed [POS_W:0]   w_dy;
    logic [POS_W-1:0]        w_adx;
    logic [POS_W-1:0]        w_ady;
    logic [SQ_W-1:0]         w_sqx;
    logic [SQ_W-1:0]         w_sqy;
    logic [DIST_W-1:0]       w_sum;
    logic [IW-1:0]           w_cur_idx;

    logic                    r1_valid;
    logic                    r1_first;
    logic [POS_W-1:0]        r1_adx;
    logic [POS_W-1:0]        r1_ady;
    logic                    r2_valid;
    logic                    r2_first;
    logic [SQ_W-1:0]         r2_sqx;
    logic [SQ_W-1:0]         r2_sqy;
    logic [DIST_W-1:0]       r_best;
    logic [IW-1:0]           r_best_idx;
    logic [IW-1:0]           r_cnt;

    // Stage 1: absolute coordinate differences
    assign w_dx  = {i_req.qx[POS_W-1], i_req.qx} - {i_req.nx[POS_W-1], i_req.nx};
    assign w_dy  = {i_req.qy[POS_W-1], i_req.qy} - {i_req.ny[POS_W-1], i_req.ny};
    assign w_adx = w_dx[POS_W] ? POS_W'(-w_dx) : w_dx[POS_W-1:0];
    assign w_ady = w_dy[POS_W] ? POS_W'(-w_dy) : w_dy[POS_W-1:0];

    // Stage 2: squares
    assign w_sqx = r1_adx * r1_adx;
    assign w_sqy = r1_ady * r1_ady;

    // Stage 3: sum, the node index counts up from the first node
    assign w_sum     = {1'b0, r2_sqx} + {1'b0, r2_sqy};
    assign w_cur_idx = r2_first ? '0 : r_cnt;

    // Advance the pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= i_req.valid;
            r2_valid <= r1_valid;
        end
    end

    // Hold payload and the running minimum; a tie goes to the later node
    always_ff @(posedge i_clk) begin
        r1_first <= i_req.first;
        r1_adx   <= w_adx;
        r1_ady   <= w_ady;
        r2_first <= r1_first;
        r2_sqx   <= w_sqx;
        r2_sqy   <= w_sqy;
        if (r2_valid) begin
            if (r2_first || w_sum <= r_best) begin
                r_best     <= w_sum;
                r_best_idx <= w_cur_idx;
            end
            r_cnt <= w_cur_idx + IW'(1);
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best;

endmodule

`default_nettype wire

// ===== rtl/graph_node_table_nearest_search.sv =====
// Flow: add_node executes then finishes; set_edge adds a second RAM write, read_edge a RAM read wait;
// find_nearest turns the node ring once past the shared distance pipeline, then drains it.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: node count cleared; the adjacency RAM is then zeroed one entry a cycle,
// all 2**(2*ceil(log2(MAX_NODES))) entries (4096 at 64 nodes), with the input stalled.
`default_nettype none

module graph_node_table_nearest_search #(
    parameter int MAX_NODES = gnns_pkg::MAX_NODES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [gnns_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [gnns_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [gnns_pkg::POS_W-1:0]    i_pos_y,
    input  logic [gnns_pkg::IDX_PORT_W-1:0]      i_node_a,
    input  logic [gnns_pkg::IDX_PORT_W-1:0]      i_node_b,
    input  logic signed [gnns_pkg::WGT_W-1:0]    i_weight,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [gnns_pkg::STATUS_W-1:0]        o_status,
    output logic [gnns_pkg::IDX_PORT_W-1:0]      o_node_index,
    output logic [gnns_pkg::DIST_W-1:0]          o_dist_sq,
    output logic [gnns_pkg::EW_W-1:0]            o_edge_weight
);
    import gnns_pkg::*;

    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int CMPW  = (CW > IDX_PORT_W) ? CW : IDX_PORT_W;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WR2,
        S_RDWAIT,
        S_SEARCH,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr;
    logic [CW-1:0]            r_count;
    logic [IW-1:0]            r_step;
    logic [1:0]               r_drain;

    // Latched request
    t_cmd                     r_cmd;
    logic signed [POS_W-1:0]  r_px;
    logic signed [POS_W-1:0]  r_py;
    logic [IDX_PORT_W-1:0]    r_a;
    logic [IDX_PORT_W-1:0]    r_b;
    logic [WGT_W-1:0]         r_w;

    // Pending result and output register
    t_status                  r_res_status;
    logic [IDX_PORT_W-1:0]    r_res_idx;
    logic [DIST_W-1:0]        r_res_dist;
    logic [EW_W-1:0]          r_res_ew;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [IDX_PORT_W-1:0]    r_out_idx;
    logic [DIST_W-1:0]        r_out_dist;
    logic [EW_W-1:0]          r_out_ew;

    logic                     w_a_ok;
    logic                     w_b_ok;
    logic                     w_full;
    logic                     w_edge_bad;
    logic [IW-1:0]            w_a_idx;
    logic [IW-1:0]            w_b_idx;
    logic                     w_ram_we;
    logic [AW-1:0]            w_ram_waddr;
    logic [EW_W-1:0]          w_ram_wdata;
    logic [AW-1:0]            w_ram_raddr;
    logic [EW_W-1:0]          w_ram_rdata;
    logic [MAX_NODES-1:0]     w_load;
    logic                     w_shift;
    logic signed [POS_W-1:0]  w_cell_x [MAX_NODES];
    logic signed [POS_W-1:0]  w_cell_y [MAX_NODES];
    t_dist_req                w_req;
    logic [IW-1:0]            w_best_idx;
    logic [DIST_W-1:0]        w_best_dist;

    // Index checks against the node count
    assign w_a_ok     = CMPW'(r_a) < CMPW'(r_count);
    assign w_b_ok     = CMPW'(r_b) < CMPW'(r_count);
    assign w_full     = r_count == CW'(MAX_NODES);
    assign w_edge_bad = !w_a_ok || !w_b_ok;
    assign w_a_idx    = IW'(r_a);
    assign w_b_idx    = IW'(r_b);

    // Adjacency RAM port control: clearing sweep, then the two symmetric writes
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = {w_a_idx, w_b_idx};
        w_ram_wdata = r_w[EW_W-1:0];
        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '0;
            end
            S_EXEC: begin
                w_ram_we = (r_cmd == CMD_SET_EDGE) && !w_edge_bad && !r_w[WGT_W-1];
            end
            S_WR2: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = {w_b_idx, w_a_idx};
            end
            default: begin
            end
        endcase
    end

    assign w_ram_raddr = {w_a_idx, w_b_idx};

    gnns_ram #(
        .WIDTH (EW_W),
        .DEPTH (DEPTH)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Node ring: cell k holds node k at rest, a search turns the ring once
    assign w_shift = (r_state == S_SEARCH);

    for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
        localparam int NEXT = (k + 1) % MAX_NODES;

        assign w_load[k] = (r_state == S_EXEC) && (r_cmd == CMD_ADD) && !w_full &&
                           (r_count == CW'(k));

        gnns_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (w_load[k]),
            .i_shift  (w_shift),
            .i_load_x (r_px),
            .i_load_y (r_py),
            .i_next_x (w_cell_x[NEXT]),
            .i_next_y (w_cell_y[NEXT]),
            .o_x      (w_cell_x[k]),
            .o_y      (w_cell_y[k])
        );
    end

    // Feed the head of the ring to the distance unit, nodes in use only
    always_comb begin
        w_req.valid = w_shift && (CW'(r_step) < r_count);
        w_req.first = (r_step == '0);
        w_req.qx    = r_px;
        w_req.qy    = r_py;
        w_req.nx    = w_cell_x[0];
        w_req.ny    = w_cell_y[0];
    end

    gnns_dist #(
        .MAX_NODES (MAX_NODES)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_best_idx  (w_best_idx),
        .o_best_dist (w_best_dist)
    );

    // Sequencer, result and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_step      <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop a taken result; the finish step reloads the register itself
            if (r_out_valid && !i_out_stall && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == {AW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= t_cmd'(i_cmd);
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_a     <= i_node_a;
                        r_b     <= i_node_b;
                        r_w     <= i_weight;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_idx  <= (r_cmd == CMD_ADD && !w_full) ? IDX_PORT_W'(r_count) : '0;
                    r_res_dist <= '0;
                    r_res_ew   <= '0;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (w_full) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_OK;
                                r_count      <= r_count + CW'(1);
                            end
                            r_state <= S_FINISH;
                        end
                        CMD_SET_EDGE: begin
                            if (w_edge_bad || r_w[WGT_W-1]) begin
                                r_res_status <= ST_BAD;
                                r_state      <= S_FINISH;
                            end else begin
                                r_res_status <= ST_OK;
                                r_state      <= S_WR2;
                            end
                        end
                        CMD_FIND: begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_FINISH;
                            end else begin
                                r_res_status <= ST_OK;
                                r_step       <= '0;
                                r_state      <= S_SEARCH;
                            end
                        end
                        CMD_READ_EDGE: begin
                            if (w_edge_bad) begin
                                r_res_status <= ST_BAD;
                                r_state      <= S_FINISH;
                            end else begin
                                r_res_status <= ST_OK;
                                r_state      <= S_RDWAIT;
                            end
                        end
                        default: begin
                            r_res_status <= ST_OK;
                            r_state      <= S_FINISH;
                        end
                    endcase
                end
                S_WR2: begin
                    r_state <= S_FINISH;
                end
                S_RDWAIT: begin
                    r_res_ew <= w_ram_rdata;
                    r_state  <= S_FINISH;
                end
                S_SEARCH: begin
                    r_step <= r_step + IW'(1);
                    if (r_step == IW'(MAX_NODES - 1)) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == DRAIN_LAST) begin
                        r_res_idx  <= IDX_PORT_W'(w_best_idx);
                        r_res_dist <= w_best_dist;
                        r_state    <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_idx    <= r_res_idx;
                        r_out_dist   <= r_res_dist;
                        r_out_ew     <= r_res_ew;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_node_index  = r_out_idx;
    assign o_dist_sq     = r_out_dist;
    assign o_edge_weight = r_out_ew;

endmodule

`default_nettype wire

// ===== rtl/gnns_checker.sv =====
// Port-level checker for the graph node table, bound to the top level.
// Uses gnns_pkg status codes.
`default_nettype none

module gnns_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic [gnns_pkg::STATUS_W-1:0]        o_status,
    input  logic [gnns_pkg::IDX_PORT_W-1:0]      o_node_index,
    input  logic [gnns_pkg::DIST_W-1:0]          o_dist_sq,
    input  logic [gnns_pkg::EW_W-1:0]            o_edge_weight
);
    import gnns_pkg::*;

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A taken request blocks the input until it is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_node_index) && $stable(o_dist_sq) && $stable(o_edge_weight))
        else $error("stalled result changed");

    // Any failing status carries no weight and no distance
    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_edge_weight == '0 && o_dist_sq == '0)
        else $error("failing result carries data");

    // An empty-table search reports node zero
    a_empty_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_node_index == '0)
        else $error("empty-table result carries an index");

endmodule

bind graph_node_table_nearest_search gnns_checker u_gnns_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for graph_node_table_nearest_search: node table, edge store, nearest search.
// Uses gnns_pkg for command and status codes, field widths and the table size.
// A tracker class predicts each reply from the accepted requests and checks the replies.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gnns_pkg::*;

    // One reply of the block, field by field
    typedef struct packed {
        t_status               status;
        logic [IDX_PORT_W-1:0] node_index;
        logic [DIST_W-1:0]     dist_sq;
        logic [EW_W-1:0]       edge_weight;
    } t_table_reply;

    // Own copy of the node table and edge store, plus the replies still owed
    class node_table_tracker;
        int                      node_count;
        logic signed [POS_W-1:0] node_x [MAX_NODES_DEF];
        logic signed [POS_W-1:0] node_y [MAX_NODES_DEF];
        logic [EW_W-1:0]         edge_store [MAX_NODES_DEF][MAX_NODES_DEF];
        t_table_reply            pending_replies [$];
        int                      mismatches;

        function void clear();
            node_count = 0;
            mismatches = 0;
            for (int i = 0; i < MAX_NODES_DEF; i++) begin
                node_x[i] = '0;
                node_y[i] = '0;
                for (int j = 0; j < MAX_NODES_DEF; j++) edge_store[i][j] = '0;
            end
        endfunction

        // Apply one accepted request and queue the reply it must produce
        function void note_request(t_cmd cmd, logic signed [POS_W-1:0] px,
                                   logic signed [POS_W-1:0] py, logic [IDX_PORT_W-1:0] a,
                                   logic [IDX_PORT_W-1:0] b, logic signed [WGT_W-1:0] w);
            t_table_reply r;
            longint       best;
            longint       node_dsq;
            longint       dx;
            longint       dy;
            r = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_ADD: begin
                    if (node_count >= MAX_NODES_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        node_x[node_count] = px;
                        node_y[node_count] = py;
                        r.node_index = IDX_PORT_W'(node_count);
                        node_count++;
                    end
                end
                CMD_SET_EDGE: begin
                    if (int'(a) >= node_count || int'(b) >= node_count || w[WGT_W-1]) begin
                        r.status = ST_BAD;
                    end else begin
                        edge_store[a][b] = w[EW_W-1:0];
                        edge_store[b][a] = w[EW_W-1:0];
                    end
                end
                CMD_FIND: begin
                    if (node_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        best = 0;
                        // Scan nodes in use; ties go to the later index
                        for (int i = 0; i < node_count; i++) begin
                            dx = longint'(px) - longint'(node_x[i]);
                            dy = longint'(py) - longint'(node_y[i]);
                            node_dsq = dx * dx + dy * dy;
                            if (i == 0 || node_dsq <= best) begin
                                best = node_dsq;
                                r.node_index = IDX_PORT_W'(i);
                            end
                        end
                        r.dist_sq = best[DIST_W-1:0];
                    end
                end
                default: begin
                    if (int'(a) >= node_count || int'(b) >= node_count) r.status = ST_BAD;
                    else r.edge_weight = edge_store[a][b];
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        // Compare one accepted reply against the oldest one owed
        function void check_reply(t_table_reply got);
            t_table_reply want;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with no request pending, status %0d", $time, got.status);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.node_index !== want.node_index) begin
                $display("%0t: node_index expected %0d actual %0d", $time,
                         want.node_index, got.node_index);
                mismatches++;
            end
            if (got.dist_sq !== want.dist_sq) begin
                $display("%0t: dist_sq expected %0d actual %0d", $time,
                         want.dist_sq, got.dist_sq);
                mismatches++;
            end
            if (got.edge_weight !== want.edge_weight) begin
                $display("%0t: edge_weight expected %0d actual %0d", $time,
                         want.edge_weight, got.edge_weight);
                mismatches++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [CMD_W-1:0]             i_cmd = '0;
    logic signed [POS_W-1:0]      i_pos_x = '0;
    logic signed [POS_W-1:0]      i_pos_y = '0;
    logic [IDX_PORT_W-1:0]        i_node_a = '0;
    logic [IDX_PORT_W-1:0]        i_node_b = '0;
    logic signed [WGT_W-1:0]      i_weight = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [STATUS_W-1:0]          o_status;
    logic [IDX_PORT_W-1:0]        o_node_index;
    logic [DIST_W-1:0]            o_dist_sq;
    logic [EW_W-1:0]              o_edge_weight;

    logic                         quiet = 1'b0;
    node_table_tracker            table_track;

    graph_node_table_nearest_search dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #2_500_000;
        $display("graph_node_table_nearest_search regression: fail");
        $finish;
    end

    // Stall the reply side at random except during the quiet stretch
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 12);
    end

    // Check every accepted reply
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            table_track.check_reply('{t_status'(o_status), o_node_index, o_dist_sq,
                                      o_edge_weight});
        end
    end

    // Present one request, hold it until accepted, then record it
    task automatic send_request(t_cmd cmd, logic signed [POS_W-1:0] px,
                                logic signed [POS_W-1:0] py, logic [IDX_PORT_W-1:0] a,
                                logic [IDX_PORT_W-1:0] b, logic signed [WGT_W-1:0] w);
        while (!quiet && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_node_a   <= a;
        i_node_b   <= b;
        i_weight   <= w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        table_track.note_request(cmd, px, py, a, b, w);
    endtask

    // Coordinates: mostly full range, some on a coarse grid to force ties, some extremes
    function automatic logic signed [POS_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return POS_W'((int'($urandom_range(0, 4)) - 2) * 256);
        if (r < 32) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return POS_W'($urandom);
    endfunction

    // Indices: mostly nodes in use, the rest anywhere in the port range
    function automatic logic [IDX_PORT_W-1:0] pick_index();
        if (table_track.node_count > 0 && $urandom_range(0, 99) < 80)
            return IDX_PORT_W'($urandom_range(0, table_track.node_count - 1));
        return IDX_PORT_W'($urandom_range(0, 63));
    endfunction

    // Edge cases on an empty and a small table
    task automatic run_directed();
        send_request(CMD_FIND,      16'h7FFF, 16'h8000, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd0,  6'd0,  16'h0100);
        send_request(CMD_ADD,       16'h8000, 16'h8000, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_FIND,      16'h7FFF, 16'h7FFF, 6'd63, 6'd63, 16'hFFFF);
        send_request(CMD_ADD,       16'h7FFF, 16'h7FFF, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_FIND,      16'h7FFF, 16'h8000, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_ADD,       16'h8000, 16'h8000, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_FIND,      16'h8000, 16'h8000, 6'd0,  6'd0,  16'h0000);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd0,  6'd1,  16'h7FFF);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd1,  6'd0,  16'h0000);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd0,  6'd1,  16'h0000);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd2,  6'd2,  16'h1234);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd2,  6'd2,  16'h0000);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd0,  6'd2,  16'hFFFF);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd0,  6'd2,  16'h8000);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd0,  6'd2,  16'h0000);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd3,  6'd0,  16'h0010);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd0,  6'd63, 16'h0010);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd63, 6'd0,  16'h0000);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd0,  6'd3,  16'h0000);
        send_request(CMD_SET_EDGE,  16'h0000, 16'h0000, 6'd1,  6'd0,  16'h0000);
        send_request(CMD_READ_EDGE, 16'h0000, 16'h0000, 6'd0,  6'd1,  16'h0000);
    endtask

    // Random mix; the table fills early so the full case and long scans get plenty of use
    task automatic run_random(int count);
        t_cmd                    cmd;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [WGT_W-1:0] w;
        int                      sel;
        int                      pick;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= 700 && n < 1000);
            sel = $urandom_range(0, 99);
            if (sel < 18)      cmd = CMD_ADD;
            else if (sel < 45) cmd = CMD_SET_EDGE;
            else if (sel < 70) cmd = CMD_FIND;
            else               cmd = CMD_READ_EDGE;
            px = pick_coord();
            py = pick_coord();
            // Aim some searches exactly at a stored node
            if (cmd == CMD_FIND && table_track.node_count > 0 && $urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, table_track.node_count - 1);
                px = table_track.node_x[pick];
                py = table_track.node_y[pick];
            end
            if ($urandom_range(0, 99) < 85) w = WGT_W'($urandom_range(0, 32767));
            else                            w = WGT_W'(16'h8000 | $urandom_range(0, 32767));
            send_request(cmd, px, py, pick_index(), pick_index(), w);
        end
        quiet = 1'b0;
    endtask

    initial begin
        table_track = new;
        table_track.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(1500);
        i_in_valid <= 1'b0;
        // Drain the replies still owed, then watch for strays
        while (table_track.pending_replies.size() != 0) @(posedge i_clk);
        repeat (MAX_NODES_DEF + 16) @(posedge i_clk);
        if (table_track.mismatches == 0 && table_track.pending_replies.size() == 0) begin
            $display("graph_node_table_nearest_search regression: pass");
        end else begin
            $display("graph_node_table_nearest_search regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== graph_node_table_nearest_search.f =====
rtl/gnns_pkg.sv
rtl/gnns_ram.sv
rtl/gnns_cell.sv
rtl/gnns_dist.sv
rtl/graph_node_table_nearest_search.sv
rtl/gnns_checker.sv
bench/tb_top.sv
